// File: rtl/cdq_pkg.sv
// Shared types and constants for the coordinate deque.
`default_nettype none

package cdq_pkg;

  localparam int unsigned DEPTH_DEFAULT      = 64;
  localparam int unsigned COORD_BITS_DEFAULT = 16;
  localparam int unsigned COORD_PORT_W       = 16;
  localparam int unsigned STATE_W            = 8;
  localparam int unsigned LENGTH_W           = 7;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_PUSH   = 2'd1,
    KIND_POP    = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_cmd_t;

endpackage

`default_nettype wire

// File: rtl/cdq_store.sv
// Entry memory with registered read port and key compare on the read data.
`default_nettype none

module cdq_store #(
  parameter int unsigned DEPTH   = cdq_pkg::DEPTH_DEFAULT,
  parameter int unsigned COORD_W = cdq_pkg::COORD_BITS_DEFAULT
) (
  input  wire logic                       clk_i,
  input  wire cdq_pkg::mem_cmd_t          cmd_i,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr_i,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr_i,
  input  wire logic [COORD_W-1:0]         key_x_i,
  input  wire logic [COORD_W-1:0]         key_y_i,
  input  wire logic [cdq_pkg::STATE_W-1:0] key_s_i,
  output logic      [COORD_W-1:0]         rd_x_o,
  output logic      [COORD_W-1:0]         rd_y_o,
  output logic      [cdq_pkg::STATE_W-1:0] rd_s_o,
  output logic                            match_o
);

  localparam int unsigned EntW = 2 * COORD_W + cdq_pkg::STATE_W;

  logic [EntW-1:0] mem_q [DEPTH];
  logic [EntW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr_i] <= {key_x_i, key_y_i, key_s_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_x_o  = rd_data_q[EntW-1 -: COORD_W];
  assign rd_y_o  = rd_data_q[cdq_pkg::STATE_W +: COORD_W];
  assign rd_s_o  = rd_data_q[cdq_pkg::STATE_W-1:0];
  assign match_o = (rd_x_o == key_x_i) && (rd_y_o == key_y_i);

endmodule

`default_nettype wire

// File: rtl/coordinate_deque_unique_append_core.sv
// Top level: ring-buffer deque of (x, y, state) entries with duplicate-checked append.
// Append scans the live entries one memory read per cycle and stays busy until the scan
//   decides (a duplicate ends the scan early); a new transaction is taken only when idle.
// Pop passes through ST_POP_RD and ST_POP_DATA (registered memory read); push, clear and empty pop use ST_EXEC.
// The result strobe done_o lasts one cycle; busy is already low then, start may follow.
// Reset empties the deque (head and count to zero); memory contents are not cleared.
`default_nettype none

module coordinate_deque_unique_append_core #(
  parameter int unsigned DEPTH      = cdq_pkg::DEPTH_DEFAULT,
  parameter int unsigned COORD_BITS = cdq_pkg::COORD_BITS_DEFAULT
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [1:0]                       kind_i,
  input  wire logic [cdq_pkg::COORD_PORT_W-1:0] x_coord_i,
  input  wire logic [cdq_pkg::COORD_PORT_W-1:0] y_coord_i,
  input  wire logic [cdq_pkg::STATE_W-1:0]      cell_state_i,
  output logic                                  done_o,
  output logic                                  popped_valid_o,
  output logic      [cdq_pkg::COORD_PORT_W-1:0] popped_x_o,
  output logic      [cdq_pkg::COORD_PORT_W-1:0] popped_y_o,
  output logic      [cdq_pkg::STATE_W-1:0]      popped_state_o,
  output logic                                  inserted_o,
  output logic                                  duplicate_o,
  output logic                                  overflow_o,
  output logic      [cdq_pkg::LENGTH_W-1:0]     length_o,
  output logic                                  is_empty_o
);

  localparam int unsigned PortW  = cdq_pkg::COORD_PORT_W;
  localparam int unsigned StW    = cdq_pkg::STATE_W;
  localparam int unsigned LenW   = cdq_pkg::LENGTH_W;
  localparam int unsigned CoordW = (COORD_BITS < PortW) ? COORD_BITS : PortW;
  localparam int unsigned PtrW   = $clog2(DEPTH);
  localparam int unsigned CntW   = $clog2(DEPTH + 1);
  localparam int unsigned SumW   = CntW + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC,
    ST_POP_RD,
    ST_POP_DATA
  } state_e;

  state_e          state_q;
  cdq_pkg::kind_e  kind_q;
  logic [CoordW-1:0] x_q, y_q;
  logic [StW-1:0]  s_q;
  logic [PtrW-1:0] head_q;
  logic [CntW-1:0] count_q;
  logic [PtrW-1:0] scan_ptr_q;
  logic [CntW-1:0] scan_left_q;
  logic            pend_q;

  logic            done_q, popped_valid_q, inserted_q, duplicate_q, overflow_q;
  logic [PortW-1:0] popped_x_q, popped_y_q;
  logic [StW-1:0]  popped_state_q;

  cdq_pkg::mem_cmd_t mem_cmd;
  logic [PtrW-1:0] rd_addr, wr_addr;
  logic [CoordW-1:0] rd_x, rd_y;
  logic [StW-1:0]  rd_s;
  logic            match;

  logic            full;
  logic            scan_hit, scan_miss;
  logic [PtrW-1:0] head_inc, head_dec, scan_inc, tail;
  logic [SumW-1:0] tail_sum;
  logic [LenW+CntW-1:0] len_ext;

  assign full      = (count_q == CntW'(DEPTH));
  assign scan_hit  = pend_q && match;
  assign scan_miss = (scan_left_q == '0) && !scan_hit;

  assign head_inc = (head_q == PtrW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign head_dec = (head_q == '0) ? PtrW'(DEPTH - 1) : head_q - 1'b1;
  assign scan_inc = (scan_ptr_q == PtrW'(DEPTH - 1)) ? '0 : scan_ptr_q + 1'b1;

  // head + count stays below 2*DEPTH, one conditional subtract wraps it
  always_comb begin
    tail_sum = SumW'(head_q) + SumW'(count_q);
    if (tail_sum >= SumW'(DEPTH)) begin
      tail_sum = tail_sum - SumW'(DEPTH);
    end
    tail = tail_sum[PtrW-1:0];
  end

  // Scan never overlaps a write: the write comes only in the deciding cycle.
  always_comb begin
    mem_cmd.rd_en = ((state_q == ST_SCAN) && (scan_left_q != '0)) || (state_q == ST_POP_RD);
    mem_cmd.wr_en = ((state_q == ST_SCAN) && scan_miss && !full) ||
                    ((state_q == ST_EXEC) && (kind_q == cdq_pkg::KIND_PUSH) && !full);
    rd_addr       = (state_q == ST_POP_RD) ? head_q : scan_ptr_q;
    wr_addr       = (state_q == ST_SCAN) ? tail : head_dec;
  end

  cdq_store #(
    .DEPTH   (DEPTH),
    .COORD_W (CoordW)
  ) u_store (
    .clk_i     (clk_i),
    .cmd_i     (mem_cmd),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .key_x_i   (x_q),
    .key_y_i   (y_q),
    .key_s_i   (s_q),
    .rd_x_o    (rd_x),
    .rd_y_o    (rd_y),
    .rd_s_o    (rd_s),
    .match_o   (match)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      kind_q         <= cdq_pkg::KIND_APPEND;
      x_q            <= '0;
      y_q            <= '0;
      s_q            <= '0;
      head_q         <= '0;
      count_q        <= '0;
      scan_ptr_q     <= '0;
      scan_left_q    <= '0;
      pend_q         <= 1'b0;
      done_q         <= 1'b0;
      popped_valid_q <= 1'b0;
      popped_x_q     <= '0;
      popped_y_q     <= '0;
      popped_state_q <= '0;
      inserted_q     <= 1'b0;
      duplicate_q    <= 1'b0;
      overflow_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            kind_q         <= cdq_pkg::kind_e'(kind_i);
            x_q            <= x_coord_i[CoordW-1:0];
            y_q            <= y_coord_i[CoordW-1:0];
            s_q            <= cell_state_i;
            scan_ptr_q     <= head_q;
            scan_left_q    <= count_q;
            pend_q         <= 1'b0;
            popped_valid_q <= 1'b0;
            popped_x_q     <= '0;
            popped_y_q     <= '0;
            popped_state_q <= '0;
            inserted_q     <= 1'b0;
            duplicate_q    <= 1'b0;
            overflow_q     <= 1'b0;
            unique case (cdq_pkg::kind_e'(kind_i))
              cdq_pkg::KIND_APPEND: state_q <= ST_SCAN;
              cdq_pkg::KIND_POP:    state_q <= (count_q != '0) ? ST_POP_RD : ST_EXEC;
              default:              state_q <= ST_EXEC;
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_hit) begin
            duplicate_q <= 1'b1;
            done_q      <= 1'b1;
            state_q     <= ST_IDLE;
          end else if (scan_miss) begin
            if (full) begin
              overflow_q <= 1'b1;
            end else begin
              count_q    <= count_q + 1'b1;
              inserted_q <= 1'b1;
            end
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            pend_q      <= 1'b1;
            scan_left_q <= scan_left_q - 1'b1;
            scan_ptr_q  <= scan_inc;
          end
        end
        ST_EXEC: begin
          unique case (kind_q)
            cdq_pkg::KIND_PUSH: begin
              if (full) begin
                overflow_q <= 1'b1;
              end else begin
                head_q     <= head_dec;
                count_q    <= count_q + 1'b1;
                inserted_q <= 1'b1;
              end
            end
            cdq_pkg::KIND_CLEAR: begin
              head_q  <= '0;
              count_q <= '0;
            end
            default: begin
              // pop of an empty deque: all flags stay low
            end
          endcase
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        ST_POP_RD: begin
          state_q <= ST_POP_DATA;
        end
        ST_POP_DATA: begin
          popped_valid_q <= 1'b1;
          popped_x_q     <= PortW'(rd_x);
          popped_y_q     <= PortW'(rd_y);
          popped_state_q <= rd_s;
          head_q         <= head_inc;
          count_q        <= count_q - 1'b1;
          done_q         <= 1'b1;
          state_q        <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // count only changes inside a busy period, so it holds the post-op value while done_o is up
  assign len_ext = {{LenW{1'b0}}, count_q};

  assign busy           = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign popped_valid_o = popped_valid_q;
  assign popped_x_o     = popped_x_q;
  assign popped_y_o     = popped_y_q;
  assign popped_state_o = popped_state_q;
  assign inserted_o     = inserted_q;
  assign duplicate_o    = duplicate_q;
  assign overflow_o     = overflow_q;
  assign length_o       = len_ext[LenW-1:0];
  assign is_empty_o     = (count_q == '0);

endmodule

`default_nettype wire

// File: rtl/cdq_checker.sv
// Port-level assertions for the coordinate deque, bound to the top level.
`default_nettype none

module cdq_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             start,
  input wire logic                             busy,
  input wire logic                             done_o,
  input wire logic                             popped_valid_o,
  input wire logic                             inserted_o,
  input wire logic                             duplicate_o,
  input wire logic                             overflow_o,
  input wire logic                             is_empty_o
);

  // an accepted transaction always raises busy in the cycle after start
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy && $past(busy))
    else $error("result strobe not at the end of a busy period");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $onehot0({popped_valid_o, inserted_o, duplicate_o, overflow_o}))
    else $error("more than one outcome flag in a result");

  a_insert_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && inserted_o |-> !is_empty_o)
    else $error("deque reported empty after an insert");

endmodule

bind coordinate_deque_unique_append_core cdq_checker u_cdq_checker (.*);

`default_nettype wire
